### rtl/rrfp_pkg.sv
// Shared types and constants of the receiver response frame parser.
package rrfp_pkg;

	localparam int STORE_DEPTH = 11;
	localparam int IDX_W = $clog2(STORE_DEPTH);

	typedef logic [3:0] count_t;
	typedef logic [IDX_W-1:0] index_t;

	// Header bytes that open a frame.
	localparam logic [7:0] HDR_SIGNAL = 8'h58;  // 'X'
	localparam logic [7:0] HDR_ERROR = 8'h5A;   // 'Z'
	localparam logic [7:0] HDR_VERSION = 8'h56; // 'V'
	localparam logic [7:0] HDR_POWERON = 8'h44; // 'D'

	// Bytes that follow each header.
	localparam count_t LEN_SIGNAL = 4'd3;
	localparam count_t LEN_ERROR = 4'd1;
	localparam count_t LEN_VERSION = 4'd6;
	localparam count_t LEN_POWERON = 4'd10;

	localparam logic [23:0] VER_TAG = "VER";
	localparam logic [71:0] DSP_TAG = "DSP START";

	localparam logic [15:0] VERSION_VALUE = 16'd103;
	localparam logic [15:0] POWERON_VALUE = 16'd1;
	localparam logic [15:0] ERROR_VALUE = 16'd0;

	typedef enum logic [1:0] {
		KIND_SIGNAL = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_VERSION = 2'd2,
		KIND_POWERON = 2'd3
	} event_kind_t;

	// Frame tracking state, brought out of the core for checking.
	typedef struct packed {
		count_t bytes_left;
		index_t write_index;
	} rrfp_status_t;

endpackage

### rtl/rrfp_in_stage.sv
// Input register stage of the frame parser with its stall generation.
module rrfp_in_stage
	import rrfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       in_stall,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic accept;

	// The stage holds its byte only while the core cannot take it.
	assign in_stall = valid_s1 & ~advance;
	assign accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

### rtl/rrfp_frame_core.sv
// Frame state, byte store, end-of-frame decode and result register.
module rrfp_frame_core
	import rrfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s1,
	input  logic [7:0]   byte_s1,
	input  logic         out_stall,
	output logic         advance,
	output logic         out_valid,
	output logic [1:0]   event_kind,
	output logic [15:0]  event_value,
	output rrfp_status_t status
);

	count_t bytes_left_q;
	index_t write_index_q;
	logic [7:0] frame_store_q [STORE_DEPTH];

	count_t bytes_left_d;
	index_t write_index_d;
	logic store_we;
	index_t store_wa;
	logic emit;
	event_kind_t kind_d;
	logic [15:0] value_d;
	logic out_valid_s2;
	event_kind_t kind_s2;
	logic [15:0] value_s2;

	assign advance = valid_s1 & (~out_valid_s2 | ~out_stall);

	always_comb begin
		bytes_left_d = bytes_left_q;
		write_index_d = write_index_q;
		store_we = 1'b0;
		store_wa = write_index_q;
		emit = 1'b0;
		kind_d = KIND_ERROR;
		value_d = ERROR_VALUE;
		if (bytes_left_q == '0) begin
			write_index_d = index_t'(1);
			store_wa = '0;
			store_we = 1'b1;
			unique case (byte_s1)
				HDR_SIGNAL: bytes_left_d = LEN_SIGNAL;
				HDR_ERROR: bytes_left_d = LEN_ERROR;
				HDR_VERSION: bytes_left_d = LEN_VERSION;
				HDR_POWERON: bytes_left_d = LEN_POWERON;
				default: store_we = 1'b0;
			endcase
		end else begin
			if (write_index_q < index_t'(STORE_DEPTH)) begin
				store_we = 1'b1;
				write_index_d = write_index_q + index_t'(1);
			end
			bytes_left_d = bytes_left_q - count_t'(1);
			// The last byte closes the frame; only earlier entries are examined.
			if (bytes_left_q == count_t'(1)) begin
				if (frame_store_q[0] == HDR_SIGNAL) begin
					emit = 1'b1;
					kind_d = KIND_SIGNAL;
					value_d = {frame_store_q[1], frame_store_q[2]};
				end else if (frame_store_q[0] == HDR_ERROR) begin
					emit = 1'b1;
					kind_d = KIND_ERROR;
					value_d = ERROR_VALUE;
				end else if ({frame_store_q[0], frame_store_q[1], frame_store_q[2]}
						== VER_TAG) begin
					emit = 1'b1;
					kind_d = KIND_VERSION;
					value_d = VERSION_VALUE;
				end else if ({frame_store_q[0], frame_store_q[1], frame_store_q[2],
						frame_store_q[3], frame_store_q[4], frame_store_q[5],
						frame_store_q[6], frame_store_q[7], frame_store_q[8]}
						== DSP_TAG) begin
					emit = 1'b1;
					kind_d = KIND_POWERON;
					value_d = POWERON_VALUE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			write_index_q <= '0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				bytes_left_q <= bytes_left_d;
				write_index_q <= write_index_d;
				out_valid_s2 <= emit;
			end else if (!out_stall) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && store_we) begin
			frame_store_q[store_wa] <= byte_s1;
		end
		if (advance && emit) begin
			kind_s2 <= kind_d;
			value_s2 <= value_d;
		end
	end

	assign out_valid = out_valid_s2;
	assign event_kind = kind_s2;
	assign event_value = value_s2;
	assign status.bytes_left = bytes_left_q;
	assign status.write_index = write_index_q;

endmodule

### rtl/receiver_response_frame_parser.sv
// Top level of the receiver response frame parser.
//
//   channel   direction  handshake            payload
//   input     in         in_valid, in_stall   rx_byte
//   output    out        out_valid, out_stall event_kind, event_value
//
// Each received byte passes through the input register and then through the
// frame decode into the result register. A new byte is accepted every cycle
// while results flow; the single result register sets that rate.
// Reset (arst_n low) returns the parser to idle with no open frame.
// A stalled result holds the core, and the input register then raises in_stall.
module receiver_response_frame_parser
	import rrfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [15:0] event_value
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic advance;
	rrfp_status_t status;

	// The input register holds one request until the core takes it.
	rrfp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// The core tracks the open frame, stores its bytes and decodes the
	// event when the last byte of a frame arrives.
	rrfp_frame_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1),
		.out_stall   (out_stall),
		.advance     (advance),
		.out_valid   (out_valid),
		.event_kind  (event_kind),
		.event_value (event_value),
		.status      (status)
	);

	// The input side only stalls when a result is blocked downstream.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked result");

	// No frame is longer than the power-on frame.
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.bytes_left <= LEN_POWERON)
		else $error("bytes_left beyond the longest frame");

	// Inside a frame the store index never leaves the store.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(status.bytes_left != '0) |-> (status.write_index < index_t'(STORE_DEPTH)))
		else $error("write index out of the store inside a frame");

	// A new result always comes from a request held in the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result appeared without a request");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench of the receiver response frame parser.
module tb_top;
	import rrfp_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 4;
	// Target of push_byte requests, the 24 of the directed part included; noise is not counted.
	localparam int FRAMED_TARGET = 925;
	// Once this few requests are left in the queue, neither side starts a new idle burst.
	localparam int QUIET_TAIL = 120;
	// The receiver's long hold-off, counted in its own cycles after reset.
	localparam int HOLD_START = 400;
	localparam int HOLD_CYCLES = 80;
	// Settle time after the expected events are in; it lets stray results show up.
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 2000;
	// The limit is set to cover the slowest correct run, which has idle bursts on
	// the sender side, stall bursts on the receiver side and the long hold-off.
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [7:0] NOISE_SPACE = 8'h20;

	typedef struct packed {
		event_kind_t kind;
		logic [15:0] value;
	} frame_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  event_kind;
	logic [15:0] event_value;

	// Bytes waiting to be offered, and events the parser still owes us.
	logic [7:0]   byte_q[$];
	frame_event_t expected_events[$];

	int fail_count = 0;
	int cycle_count = 0;
	int framed_bytes = 0;
	int gap_left = 0;
	int stall_left = 0;
	int recv_cycles = 0;
	frame_event_t seen_event;

	// Our own copy of the parser state. The store is only ever read at entries
	// that the current frame wrote, so it needs no reset value.
	count_t      frame_left = '0;
	logic [3:0]  store_pos = '0;
	logic [7:0]  frame_bytes [STORE_DEPTH];

	receiver_response_frame_parser u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.event_value (event_value)
	);

	always #CLK_HALF clk = ~clk;

	// Feeds one received byte through the frame parser and tells whether the
	// byte closed a frame that yields an event.
	function automatic bit parse_byte(input logic [7:0] b, output frame_event_t ev);
		logic [7:0] head;
		ev.kind = KIND_SIGNAL;
		ev.value = 16'd0;
		if (frame_left == 0) begin
			// Idle: only a header opens a frame; anything else is line noise.
			store_pos = 4'd1;
			case (b)
				HDR_SIGNAL: frame_left = LEN_SIGNAL;
				HDR_ERROR: frame_left = LEN_ERROR;
				HDR_VERSION: frame_left = LEN_VERSION;
				HDR_POWERON: frame_left = LEN_POWERON;
				default: return 1'b0;
			endcase
			frame_bytes[0] = b;
			return 1'b0;
		end
		if (store_pos < STORE_DEPTH) begin
			frame_bytes[store_pos] = b;
			store_pos = store_pos + 4'd1;
		end
		frame_left = frame_left - 4'd1;
		if (frame_left != 0)
			return 1'b0;
		head = frame_bytes[0];
		if (head == HDR_SIGNAL) begin
			// The third data byte of a signal frame is stored but plays no part.
			ev.kind = KIND_SIGNAL;
			ev.value = {frame_bytes[1], frame_bytes[2]};
			return 1'b1;
		end
		if (head == HDR_ERROR) begin
			ev.kind = KIND_ERROR;
			ev.value = ERROR_VALUE;
			return 1'b1;
		end
		if ({frame_bytes[0], frame_bytes[1], frame_bytes[2]} == VER_TAG) begin
			ev.kind = KIND_VERSION;
			ev.value = VERSION_VALUE;
			return 1'b1;
		end
		if ({frame_bytes[0], frame_bytes[1], frame_bytes[2], frame_bytes[3], frame_bytes[4],
				frame_bytes[5], frame_bytes[6], frame_bytes[7], frame_bytes[8]} == DSP_TAG) begin
			ev.kind = KIND_POWERON;
			ev.value = POWERON_VALUE;
			return 1'b1;
		end
		// A version or power-on frame whose text does not match gives nothing.
		return 1'b0;
	endfunction

	// Data bytes lean toward the extremes now and then.
	function automatic logic [7:0] rand_data();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Idling is off near the end of the run, and in one of every four blocks of
	// 64 requests, so that long back-to-back stretches occur as well.
	function automatic bit idling_allowed();
		return byte_q.size() > QUIET_TAIL && (byte_q.size() / 64) % 4 != 0;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		byte_q.push_back(b);
		framed_bytes++;
	endtask

	// Sender: offers the next byte once the current request is taken, with
	// random idle bursts. Valid stays up while stalled and the byte on rx_byte
	// does not change until it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			gap_left = 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (idling_allowed() && $urandom_range(0, 11) == 0) begin
				gap_left = $urandom_range(0, 8);
				in_valid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= byte_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off while the sender
	// keeps offering bytes, so that the result register and then the input
	// register fill up and in_stall is raised.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			recv_cycles = 0;
		end else begin
			recv_cycles++;
			if (recv_cycles == HOLD_START)
				stall_left = HOLD_CYCLES;
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idling_allowed() && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(0, 8);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: checks every accepted result against the oldest expected event,
	// then runs every accepted request through the predictor. Both sample the
	// values that stood before this edge, since all drivers use nonblocking
	// assignments.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					$error("unexpected event: event_kind %0d, event_value %0d",
						event_kind, event_value);
					fail_count++;
				end else begin
					seen_event = expected_events.pop_front();
					if (event_kind !== seen_event.kind) begin
						$error("event_kind: expected %0d, actual %0d",
							seen_event.kind, event_kind);
						fail_count++;
					end
					if (event_value !== seen_event.value) begin
						$error("event_value: expected %0d, actual %0d",
							seen_event.value, event_value);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (parse_byte(rx_byte, seen_event))
					expected_events.push_back(seen_event);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("receiver_response_frame_parser regression: fail");
			$finish;
		end
	end

	initial begin
		logic [7:0] b;
		logic [7:0] noise;
		bit broken;
		int pos;
		int run_len;
		int drain;

		// Directed part: noise bytes (a space and both extremes), a signal frame
		// with extreme data, an error frame, and matching version and power-on
		// frames.
		byte_q.push_back(NOISE_SPACE);
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		push_byte(HDR_SIGNAL);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(HDR_ERROR);
		push_byte(8'h00);
		for (int i = 0; i < 3; i++)
			push_byte(VER_TAG[23 - 8 * i -: 8]);
		repeat (LEN_VERSION - 2) push_byte(rand_data());
		for (int i = 0; i < 9; i++)
			push_byte(DSP_TAG[71 - 8 * i -: 8]);
		repeat (LEN_POWERON - 8) push_byte(rand_data());

		// Random part: mostly well-formed frames with random content, some with
		// a corrupted tag, plus line noise and runs of fully random bytes.
		while (framed_bytes < FRAMED_TARGET) begin
			case ($urandom_range(0, 9))
				0: begin
					do
						noise = 8'($urandom_range(0, 255));
					while (noise == HDR_SIGNAL || noise == HDR_ERROR ||
						noise == HDR_VERSION || noise == HDR_POWERON);
					byte_q.push_back(noise);
				end
				1, 2, 3: begin
					push_byte(HDR_SIGNAL);
					repeat (LEN_SIGNAL) push_byte(rand_data());
				end
				4: begin
					push_byte(HDR_ERROR);
					repeat (LEN_ERROR) push_byte(rand_data());
				end
				5, 6: begin
					broken = ($urandom_range(0, 3) == 0);
					pos = $urandom_range(1, 2);
					for (int i = 0; i < 3; i++) begin
						b = VER_TAG[23 - 8 * i -: 8];
						if (broken && i == pos)
							b = b ^ 8'($urandom_range(1, 255));
						push_byte(b);
					end
					repeat (LEN_VERSION - 2) push_byte(rand_data());
				end
				7, 8: begin
					broken = ($urandom_range(0, 3) == 0);
					pos = $urandom_range(1, 8);
					for (int i = 0; i < 9; i++) begin
						b = DSP_TAG[71 - 8 * i -: 8];
						if (broken && i == pos)
							b = b ^ 8'($urandom_range(1, 255));
						push_byte(b);
					end
					repeat (LEN_POWERON - 8) push_byte(rand_data());
				end
				default: begin
					// Fully random bytes put headers in the middle of frames too.
					run_len = $urandom_range(1, 12);
					repeat (run_len) push_byte(8'($urandom_range(0, 255)));
				end
			endcase
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (byte_q.size() != 0 || in_valid)
			@(posedge clk);
		drain = 0;
		while (expected_events.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_events.size() != 0) begin
			$error("%0d expected events never arrived", expected_events.size());
			fail_count++;
		end

		if (fail_count == 0) begin
			$display("receiver_response_frame_parser regression: pass");
		end else begin
			$display("receiver_response_frame_parser regression: fail");
		end
		$finish;
	end

endmodule
